// ===== design/aip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared constants and character-class helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int DEFAULT_MAX_LEN = 4096;

    localparam int CH_W     = 8;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 7;
    localparam int VALUE_W  = 64;
    localparam int END_W    = 12;

    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0d;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_8    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_10   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_16   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    // Digit weight of a character, DIGIT_NONE for anything else.
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] off;
        begin
            off = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                off = c - CH_ZERO;
                digit_value = DIGIT_W'(off);
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                off = c - CH_LOWER_A + 8'd10;
                digit_value = DIGIT_W'(off);
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                off = c - CH_UPPER_A + 8'd10;
                digit_value = DIGIT_W'(off);
            end else begin
                digit_value = DIGIT_NONE;
            end
        end
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== design/ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming text to signed 64-bit integer converter with strtol semantics.
// ----------------------------------------------------------------------------
// One character is taken per cycle, sustained, as long as the result side
// keeps up; the character that ends the number enters the input register,
// then its result enters the result register. The timing limit is the
// accumulator update: a 64 by 6 bit multiply by the radix plus the digit and
// the compare against the signed limit, all combinational. A new string
// starts when s_first is high; after a result, characters are consumed silently
// until the next s_first. The user must write number_base (0 = automatic)
// through cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [BASE_W-1:0]    cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_W-1:0]      s_ch,
    input  logic                 s_first,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic [END_W-1:0]     m_end_index,
    output logic                 m_converted,
    output logic                 m_overflowed
);

    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int PROD_W = VALUE_W + BASE_W + 1;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 1);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_XSEEN  = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // configuration
    logic [BASE_W-1:0]  base_reg;

    // input register
    logic               in_valid_reg;
    logic [CH_W-1:0]    ch_reg;
    logic               first_reg;

    // parser state
    logic [2:0]         phase_reg,  phase_next;
    logic               neg_reg,    neg_next;
    logic [VALUE_W-1:0] acc_reg,    acc_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [POS_W-1:0]   zpos_reg,   zpos_next;
    logic [BASE_W-1:0]  abase_reg,  abase_next;
    logic               sat_reg,    sat_next;

    // result register
    logic               m_valid_reg;
    logic [VALUE_W-1:0] value_reg,  value_next;
    logic [END_W-1:0]   end_reg,    end_next;
    logic               conv_reg,   conv_next;
    logic               ovf_reg,    ovf_next;

    // current state, after a string restart
    logic [2:0]         cur_phase;
    logic               cur_neg;
    logic [VALUE_W-1:0] cur_acc;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   cur_zpos;
    logic [BASE_W-1:0]  cur_abase;
    logic               cur_sat;

    logic               advance;
    logic               emit;
    logic               do_acc;
    logic [DIGIT_W-1:0] dig;
    logic               bad_base;
    logic [BASE_W-1:0]  first_base;
    logic [BASE_W-1:0]  zero_base;
    logic [BASE_W-1:0]  mul_base;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  limit;
    logic               prod_ovf;
    logic [VALUE_W-1:0] final_value;
    logic [POS_W-1:0]   zpos_plus;

    // Work on the staged beat only when the result slot is free.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cur_phase = first_reg ? PH_SPACE : phase_reg;
    assign cur_neg   = first_reg ? 1'b0     : neg_reg;
    assign cur_acc   = first_reg ? '0       : acc_reg;
    assign cur_pos   = first_reg ? '0       : pos_reg;
    assign cur_zpos  = first_reg ? '0       : zpos_reg;
    assign cur_abase = first_reg ? BASE_10  : abase_reg;
    assign cur_sat   = first_reg ? 1'b0     : sat_reg;

    assign dig        = digit_value(ch_reg);
    assign bad_base   = (base_reg == BASE_ONE) || (base_reg > BASE_MAX);
    assign first_base = (base_reg == BASE_AUTO) ? BASE_10 : base_reg;
    assign zero_base  = (cur_abase == BASE_AUTO) ? BASE_8 : BASE_16;
    assign zpos_plus  = cur_zpos + POS_W'(1);

    always_comb begin
        unique case (cur_phase)
            PH_SPACE, PH_SIGN: mul_base = first_base;
            PH_ZERO:           mul_base = zero_base;
            PH_XSEEN:          mul_base = BASE_16;
            default:           mul_base = cur_abase;
        endcase
    end

    // Overflow test on the full product: acc*b + d > limit.
    assign product  = PROD_W'(cur_acc) * PROD_W'(mul_base) + PROD_W'(dig);
    assign limit    = cur_neg ? PROD_W'(VALUE_MIN) : PROD_W'(VALUE_MAX);
    assign prod_ovf = product > limit;

    always_comb begin
        if (cur_sat) begin
            final_value = cur_neg ? VALUE_MIN : VALUE_MAX;
        end else begin
            final_value = cur_neg ? (VALUE_W'(0) - cur_acc) : cur_acc;
        end
    end

    always_comb begin
        phase_next = cur_phase;
        neg_next   = cur_neg;
        zpos_next  = cur_zpos;
        abase_next = cur_abase;
        pos_next   = cur_pos;
        emit       = 1'b0;
        do_acc     = 1'b0;
        value_next = '0;
        end_next   = '0;
        conv_next  = 1'b0;
        ovf_next   = 1'b0;

        if (cur_phase != PH_DONE && cur_pos < POS_LAST) begin
            pos_next = cur_pos + POS_W'(1);
        end

        unique case (cur_phase)
            PH_SPACE, PH_SIGN: begin
                priority if (bad_base) begin
                    emit = 1'b1;
                end else if (cur_phase == PH_SPACE && is_space(ch_reg)) begin
                    phase_next = PH_SPACE;
                end else if (cur_phase == PH_SPACE
                             && (ch_reg == CH_PLUS || ch_reg == CH_MINUS)) begin
                    neg_next   = (ch_reg == CH_MINUS);
                    phase_next = PH_SIGN;
                end else if (ch_reg == CH_ZERO
                             && (base_reg == BASE_AUTO || base_reg == BASE_16)) begin
                    abase_next = base_reg;
                    zpos_next  = cur_pos;
                    phase_next = PH_ZERO;
                end else if (dig < DIGIT_W'(first_base)) begin
                    abase_next = first_base;
                    do_acc     = 1'b1;
                    phase_next = PH_DIGITS;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (ch_reg == CH_LOWER_X || ch_reg == CH_UPPER_X) begin
                    phase_next = PH_XSEEN;
                end else begin
                    abase_next = zero_base;
                    phase_next = PH_DIGITS;
                    if (dig < DIGIT_W'(zero_base)) begin
                        do_acc = 1'b1;
                    end else begin
                        emit       = 1'b1;
                        value_next = final_value;
                        end_next   = END_W'(cur_pos);
                        conv_next  = 1'b1;
                        ovf_next   = cur_sat;
                    end
                end
            end
            PH_XSEEN: begin
                abase_next = BASE_16;
                if (dig < DIGIT_W'(BASE_16)) begin
                    do_acc     = 1'b1;
                    phase_next = PH_DIGITS;
                end else begin
                    // bare prefix: only the leading zero counts
                    emit      = 1'b1;
                    end_next  = END_W'(zpos_plus);
                    conv_next = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (dig < DIGIT_W'(cur_abase)) begin
                    do_acc = 1'b1;
                end else begin
                    emit       = 1'b1;
                    value_next = final_value;
                    end_next   = END_W'(cur_pos);
                    conv_next  = 1'b1;
                    ovf_next   = cur_sat;
                end
            end
            default: begin
                // done: drop characters until the next string
                phase_next = PH_DONE;
            end
        endcase

        if (emit) begin
            phase_next = PH_DONE;
        end
    end

    always_comb begin
        acc_next = cur_acc;
        sat_next = cur_sat;
        if (do_acc && !cur_sat) begin
            if (prod_ovf) begin
                sat_next = 1'b1;
            end else begin
                acc_next = product[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_10;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg    <= s_ch;
            first_reg <= s_first;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            zpos_reg  <= '0;
            abase_reg <= BASE_10;
            sat_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            zpos_reg  <= zpos_next;
            abase_reg <= abase_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            value_reg <= value_next;
            end_reg   <= end_next;
            conv_reg  <= conv_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = value_reg;
    assign m_end_index  = end_reg;
    assign m_converted  = conv_reg;
    assign m_overflowed = ovf_reg;

    a_ovf_needs_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ovf_reg |-> conv_reg)
        else $error("overflow flagged without a conversion");

    a_noconv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !conv_reg |-> value_reg == '0 && end_reg == '0)
        else $error("failed conversion carries nonzero value or end index");

    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ovf_reg |-> value_reg == VALUE_MAX || value_reg == VALUE_MIN)
        else $error("overflowed result is not a signed limit");

    a_sat_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> phase_reg == PH_DIGITS || phase_reg == PH_DONE)
        else $error("saturation set outside digit accumulation");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |=> m_valid_reg && phase_reg == PH_DONE)
        else $error("emitted result did not reach the output register");

endmodule

// ===== bench/tb_ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Self-checking bench for the streaming text to integer converter. A local
// parser model predicts each result from the accepted characters and the
// current radix. Directed strings cover signs, prefixes, the radix extremes,
// invalid radixes, overflow, restarts and a long digit run. Random
// numbers, broken strings and noise then run with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          RANDOM_ITEMS  = 600;
    localparam int          LONG_ZEROS    = 60;
    localparam logic [7:0]  CH_NUL        = 8'h00;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_SIGNED,
        PH_LEAD_ZERO,
        PH_PREFIX_X,
        PH_DIGIT_RUN,
        PH_FINISHED
    } parse_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [END_W-1:0]   end_index;
        logic               converted;
        logic               overflowed;
    } parse_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [BASE_W-1:0]         cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [CH_W-1:0]           s_ch;
    logic                      s_first;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_value;
    logic [END_W-1:0]          m_end_index;
    logic                      m_converted;
    logic                      m_overflowed;

    ascii_integer_parser dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_first      (s_first),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_end_index  (m_end_index),
        .m_converted  (m_converted),
        .m_overflowed (m_overflowed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser model state
    parse_phase_t        phase_q;
    bit                  neg_q;
    logic [VALUE_W-1:0]  mag_q;
    int unsigned         pos_q;
    int unsigned         zero_pos_q;
    int unsigned         base_q;
    bit                  sat_q;
    logic [BASE_W-1:0]   cfg_base;

    parse_result_t       pending_results[$];
    logic [7:0]          text_q[$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    bit                  steady = 1'b0;

    function automatic int unsigned char_weight(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return c - CH_LOWER_A + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c - CH_UPPER_A + 10;
        return DIGIT_NONE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_parse();
        phase_q    = PH_BLANK;
        neg_q      = 1'b0;
        mag_q      = '0;
        pos_q      = 0;
        zero_pos_q = 0;
        base_q     = 10;
        sat_q      = 1'b0;
    endfunction

    function automatic void add_digit(input int unsigned d);
        logic [VALUE_W-1:0] lim;
        lim = neg_q ? VALUE_MIN : VALUE_MAX;
        if (sat_q)
            return;
        if (mag_q > (lim - VALUE_W'(d)) / VALUE_W'(base_q))
            sat_q = 1'b1;
        else
            mag_q = mag_q * VALUE_W'(base_q) + VALUE_W'(d);
    endfunction

    function automatic parse_result_t make_result(input logic [VALUE_W-1:0] v,
                                                  input int unsigned e,
                                                  input bit conv, input bit ovf);
        parse_result_t r;
        r.value      = v;
        r.end_index  = END_W'(e);
        r.converted  = conv;
        r.overflowed = ovf;
        phase_q      = PH_FINISHED;
        return r;
    endfunction

    function automatic parse_result_t close_number(input int unsigned e);
        logic [VALUE_W-1:0] v;
        if (sat_q)
            v = neg_q ? VALUE_MIN : VALUE_MAX;
        else
            v = neg_q ? (VALUE_W'(0) - mag_q) : mag_q;
        return make_result(v, e, 1'b1, sat_q);
    endfunction

    // Advance the model by one character; returns 1 when a result is due.
    function automatic bit parse_char(input logic [7:0] c, input bit f,
                                      output parse_result_t res);
        int unsigned d;
        int unsigned here;
        int unsigned nb;
        int unsigned b;
        bit          hit;
        d   = char_weight(c);
        nb  = cfg_base;
        hit = 1'b0;
        res = '0;
        if (f)
            clear_parse();
        if (phase_q == PH_FINISHED)
            return 1'b0;
        here = pos_q;
        if (pos_q < DEFAULT_MAX_LEN - 1)
            pos_q++;
        case (phase_q)
            PH_BLANK, PH_SIGNED: begin
                if (nb == BASE_ONE || nb > BASE_MAX) begin
                    res = make_result('0, 0, 1'b0, 1'b0);
                    hit = 1'b1;
                end else if (phase_q == PH_BLANK && is_blank(c)) begin
                    // skip leading blank
                end else if (phase_q == PH_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
                    neg_q   = (c == CH_MINUS);
                    phase_q = PH_SIGNED;
                end else if (c == CH_ZERO && (nb == BASE_AUTO || nb == BASE_16)) begin
                    base_q     = nb;
                    zero_pos_q = here;
                    phase_q    = PH_LEAD_ZERO;
                end else begin
                    b = (nb == BASE_AUTO) ? 10 : nb;
                    if (d < b) begin
                        base_q = b;
                        add_digit(d);
                        phase_q = PH_DIGIT_RUN;
                    end else begin
                        res = make_result('0, 0, 1'b0, 1'b0);
                        hit = 1'b1;
                    end
                end
            end
            PH_LEAD_ZERO: begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    phase_q = PH_PREFIX_X;
                end else begin
                    base_q  = (base_q == BASE_AUTO) ? 8 : 16;
                    phase_q = PH_DIGIT_RUN;
                    if (d < base_q) begin
                        add_digit(d);
                    end else begin
                        res = close_number(here);
                        hit = 1'b1;
                    end
                end
            end
            PH_PREFIX_X: begin
                base_q = 16;
                if (d < 16) begin
                    add_digit(d);
                    phase_q = PH_DIGIT_RUN;
                end else begin
                    // bare prefix: only the zero converts
                    res = make_result('0, zero_pos_q + 1, 1'b1, 1'b0);
                    hit = 1'b1;
                end
            end
            default: begin
                if (d < base_q) begin
                    add_digit(d);
                end else begin
                    res = close_number(here);
                    hit = 1'b1;
                end
            end
        endcase
        return hit;
    endfunction

    function automatic int pause_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10);
    endfunction

    // Send one beat; predict at acceptance.
    task automatic send_char(input logic [7:0] c, input bit f);
        int            g;
        parse_result_t r;
        g = pause_cycles();
        if (g > 0) begin
            s_valid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_ch    = c;
        s_first = f;
        do @(posedge aclk); while (!s_ready);
        if (parse_char(c, f, r))
            pending_results.push_back(r);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_text(input string s, input bit nul_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == 0);
        if (nul_end)
            send_char(CH_NUL, s.len() == 0);
    endtask

    task automatic send_text_q(input bit noisy);
        foreach (text_q[i])
            send_char(text_q[i], i == 0 || (noisy && $urandom_range(0, 9) == 0));
        text_q.delete();
    endtask

    // Hold until every result is back and the pipeline has emptied.
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_base(input logic [BASE_W-1:0] b);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = b;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cfg_base    = b;
    endtask

    // Result checker
    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result: value %0d end %0d conv %0b ovf %0b",
                                     m_value, m_end_index, m_converted, m_overflowed));
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value || m_end_index !== want.end_index ||
                    m_converted !== want.converted || m_overflowed !== want.overflowed)
                    note_error($sformatf({"result mismatch: expected value %0d end %0d ",
                                          "conv %0b ovf %0b, got value %0d end %0d ",
                                          "conv %0b ovf %0b"},
                                         $signed(want.value), want.end_index,
                                         want.converted, want.overflowed, m_value,
                                         m_end_index, m_converted, m_overflowed));
            end
        end
    end

    // Result-side stalls
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!steady && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat (1 + pause_cycles()) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic test_decimal();
        send_text(" \t-123", 1'b1);
        send_text("+0042x", 1'b0);
        send_text("-+5", 1'b0);
        send_text("", 1'b1);
        send_text("q1", 1'b0);
    endtask

    task automatic test_extremes();
        send_text("9223372036854775807", 1'b1);
        send_text("-9223372036854775808", 1'b1);
        send_text("9223372036854775808", 1'b1);
        send_text("-99999999999999999999 ", 1'b0);
    endtask

    task automatic test_prefix();
        set_base(BASE_AUTO);
        send_text("0x1fZ", 1'b0);
        send_text("0Xg", 1'b0);
        send_text("0755", 1'b1);
        send_text("089", 1'b0);
        send_text("-12", 1'b1);
        send_text("0", 1'b1);
        set_base(BASE_16);
        send_text("0xFF", 1'b1);
        send_text("-ff", 1'b1);
        send_text("0x", 1'b1);
        send_text("7fffffffffffffff0", 1'b1);
    endtask

    task automatic test_base_limits();
        set_base(6'd2);
        send_text("1012", 1'b0);
        set_base(BASE_MAX);
        send_text("zZ", 1'b1);
        set_base(BASE_8);
        send_text("778", 1'b0);
    endtask

    task automatic test_invalid_base();
        set_base(BASE_ONE);
        send_text("5", 1'b0);
        set_base(6'd37);
        send_text(" 7", 1'b0);
        set_base(6'h3f);
        send_text("+1", 1'b0);
        set_base(BASE_10);
    endtask

    // A radix write mid-number applies only from the next number on.
    task automatic test_base_latch();
        send_text("12", 1'b0);
        set_base(BASE_16);
        send_text("a", 1'b0);
        send_text("a", 1'b1);
        set_base(BASE_10);
        send_text(" ", 1'b0);
        set_base(BASE_16);
        send_text("f", 1'b1);
        set_base(BASE_10);
    endtask

    task automatic test_restart();
        send_text("12", 1'b0);
        send_text("3", 1'b1);
        send_text("45", 1'b1);
        send_text("6", 1'b0);
    endtask

    // Hold a long run of leading zeros back to back, then close the number.
    task automatic test_long_string();
        steady = 1'b1;
        send_char(CH_ZERO, 1'b1);
        repeat (LONG_ZEROS) send_char(CH_ZERO, 1'b0);
        send_char(CH_ZERO + 8'd7, 1'b0);
        send_char(CH_NUL, 1'b0);
        steady = 1'b0;
    endtask

    task automatic build_number();
        int unsigned nb;
        int unsigned b;
        int unsigned n;
        int unsigned r;
        nb = cfg_base;
        n = $urandom_range(0, 2);
        repeat (n) begin
            r = $urandom_range(0, 5);
            text_q.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
        end
        r = $urandom_range(0, 2);
        if (r == 1)
            text_q.push_back(CH_PLUS);
        else if (r == 2)
            text_q.push_back(CH_MINUS);
        b = (nb == BASE_AUTO || nb == BASE_ONE || nb > BASE_MAX) ? 10 : nb;
        if ((nb == BASE_AUTO || nb == BASE_16) && $urandom_range(0, 2) == 0) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            b = 16;
        end else if (nb == BASE_AUTO && $urandom_range(0, 2) == 0) begin
            text_q.push_back(CH_ZERO);
            b = 8;
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 26) : $urandom_range(1, 6);
        repeat (n) text_q.push_back(digit_char($urandom_range(0, b - 1)));
        r = $urandom_range(0, 3);
        if (r < 2)
            text_q.push_back(CH_NUL);
        else if (r == 2)
            text_q.push_back(CH_SPACE);
        else
            text_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_broken();
        case ($urandom_range(0, 3))
            0: begin
                text_q.push_back(CH_PLUS);
                text_q.push_back(CH_MINUS);
                text_q.push_back(digit_char($urandom_range(0, 9)));
            end
            1: begin
                text_q.push_back(CH_ZERO);
                text_q.push_back(CH_LOWER_X);
                text_q.push_back($urandom_range(0, 1) ? CH_LOWER_A + 8'd6 : CH_NUL);
            end
            2: begin
                repeat ($urandom_range(1, 4)) text_q.push_back(CH_SPACE);
                text_q.push_back(CH_NUL);
            end
            default: begin
                text_q.push_back(CH_MINUS);
                text_q.push_back($urandom_range(0, 1) ? CH_LOWER_Z : CH_NUL);
            end
        endcase
    endtask

    task automatic test_random();
        int          start;
        int          strings;
        int unsigned r;
        start   = items_sent;
        strings = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (strings % 8 == 7) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    set_base($urandom_range(0, 1) ? BASE_AUTO : BASE_16);
                else if (r < 9)
                    set_base(6'($urandom_range(2, 36)));
                else
                    set_base($urandom_range(0, 1) ? BASE_ONE : 6'($urandom_range(37, 63)));
            end
            steady = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                build_number();
                send_text_q(1'b0);
            end else if (r < 90) begin
                build_broken();
                send_text_q(1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
                send_text_q(1'b1);
            end
            strings++;
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_ch        = '0;
        s_first     = 1'b0;
        cfg_base    = BASE_10;
        clear_parse();
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_decimal();
        test_extremes();
        test_prefix();
        test_base_limits();
        test_invalid_base();
        test_base_latch();
        test_restart();
        test_long_string();
        test_random();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/aip_pkg.sv
design/ascii_integer_parser.sv
bench/tb_ascii_integer_parser.sv
